@@ src/rsi_pkg.sv @@
// Shared types and constants for the ray-sphere intersection block.
// Used by the front end, the back end and the top level.
package rsi_pkg;

  // Default queue depths between the pipeline sections and at the output.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Result classification.
  typedef enum logic [1:0] {
    KIND_MISS   = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_BEHIND = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3
  } reg_index_t;

  // Sphere description held in configuration.
  typedef struct packed {
    logic [2:0][31:0] center;
    logic [30:0]      radius;
  } cfg_t;

  // One ray: origin in Q15.16, direction in Q1.16.
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][17:0] d;
  } ray_t;

  // Sideband carried through the front square root.
  typedef struct packed {
    logic        miss;
    logic [52:0] h;
    ray_t        ray;
  } front_side_t;

  // Item passed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [37:0] tq;
    ray_t        ray;
  } mid_item_t;

  // One finished result.
  typedef struct packed {
    kind_t            kind;
    logic [30:0]      distance;
    logic [2:0][31:0] p;
    logic [2:0][17:0] n;
  } result_t;

endpackage

@@ src/ray_sphere_intersect_top.sv @@
// Ray-sphere intersection, top level. One ray is accepted per cycle while full is low.
// Each ray passes through two bit-per-stage square roots and the division on its way
// to the result ports.
// Throughput is one ray per cycle; either side may stall without losing items.
// Synchronous reset empties all pipelines and queues and loads the default sphere.
module ray_sphere_intersect_top #(
  parameter int MID_DEPTH = rsi_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = rsi_pkg::OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [17:0] dir_x,
  input  logic [17:0] dir_y,
  input  logic [17:0] dir_z,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  hit_kind,
  output logic [30:0] hit_distance,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z,
  output logic [17:0] normal_x,
  output logic [17:0] normal_y,
  output logic [17:0] normal_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rsi_pkg::*;

  cfg_t      cfg;
  ray_t      in_ray;
  logic      front_ready;
  logic      front_valid;
  mid_item_t front_item;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_pop;
  mid_item_t mid_item;
  logic      back_ready;
  logic      back_valid;
  result_t   back_res;
  logic      out_full;
  result_t   out_res;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= '0;
      cfg.radius <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg.center[0] <= cfg_data;
        REG_CENTER_Y: cfg.center[1] <= cfg_data;
        REG_CENTER_Z: cfg.center[2] <= cfg_data;
        REG_RADIUS:   cfg.radius    <= cfg_data[30:0];
        default:      ;
      endcase
    end
  end

  // Input ray.
  assign in_ray.o = {origin_z, origin_y, origin_x};
  assign in_ray.d = {dir_z, dir_y, dir_x};
  assign full     = !front_ready;

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (push && !full),
    .in_ray    (in_ray),
    .ready     (front_ready),
    .mid_full  (mid_full),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  // Queue between the classifying front and the shading back.
  rsi_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid && front_ready),
    .push_data (front_item),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_item),
    .empty     (mid_empty)
  );

  assign mid_pop = back_ready && !mid_empty;

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mid_pop),
    .in_item   (mid_item),
    .ready     (back_ready),
    .out_full  (out_full),
    .out_valid (back_valid),
    .out_res   (back_res)
  );

  // Result queue facing the consumer.
  rsi_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (back_valid && back_ready),
    .push_data (back_res),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_res),
    .empty     (empty)
  );

  assign hit_kind     = out_res.kind;
  assign hit_distance = out_res.distance;
  assign point_x      = out_res.p[0];
  assign point_y      = out_res.p[1];
  assign point_z      = out_res.p[2];
  assign normal_x     = out_res.n[0];
  assign normal_y     = out_res.n[1];
  assign normal_z     = out_res.n[2];

  // A result that is not a hit carries nothing but its kind.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (hit_kind != KIND_HIT)) |->
      ((hit_distance == '0) && (point_x == '0) && (point_y == '0) && (point_z == '0) &&
       (normal_x == '0) && (normal_y == '0) && (normal_z == '0)))
    else $error("non-hit result carries payload");

  // Normal components stay within one in magnitude.
  assert property (@(posedge clk) disable iff (rst)
    !empty |->
      (($signed(normal_x) >= -18'sd65536) && ($signed(normal_x) <= 18'sd65536) &&
       ($signed(normal_y) >= -18'sd65536) && ($signed(normal_y) <= 18'sd65536) &&
       ($signed(normal_z) >= -18'sd65536) && ($signed(normal_z) <= 18'sd65536)))
    else $error("normal component out of range");

  // Reset leaves no result waiting.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule

@@ src/rsi_fifo.sv @@
// Small register queue used between the pipeline sections and at the output.
// Depends on nothing but its parameters.
module rsi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rsi_sqrt.sv @@
// Pipelined floor square root, one root bit per stage, with a sideband.
// Depends on nothing but its parameters; the whole pipe advances on en.
module rsi_sqrt #(
  parameter int XW = 104,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [XW-1:0]   in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [XW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = XW / 2;

  logic          valid [0:RW];
  logic [RW+1:0] rem   [0:RW];
  logic [RW-1:0] root  [0:RW];
  logic [XW-1:0] xs    [0:RW];
  logic [SW-1:0] side  [0:RW];

  // Entry stage captures the radicand.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= '0;
      root[0] <= '0;
      xs[0]   <= in_x;
      side[0] <= in_side;
    end
  end

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;

    always_comb begin
      sh    = {rem[s][RW-1:0], xs[s][XW-1 -: 2]};
      trial = {root[s], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (en) begin
        valid[s+1] <= valid[s];
      end
      if (en) begin
        if (sh >= trial) begin
          rem[s+1]  <= sh - trial;
          root[s+1] <= {root[s][RW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= sh;
          root[s+1] <= {root[s][RW-2:0], 1'b0};
        end
        xs[s+1]   <= {xs[s][XW-3:0], 2'b00};
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = valid[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

@@ src/rsi_front.sv @@
// Front end: takes rays, forms the discriminant, its root and the nearer root.
// Depends on rsi_pkg and rsi_sqrt; classifies each ray as miss, behind or hit.
module rsi_front (
  input  logic                clk,
  input  logic                rst,
  input  rsi_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  rsi_pkg::ray_t       in_ray,
  output logic                ready,
  input  logic                mid_full,
  output logic                out_valid,
  output rsi_pkg::mid_item_t  out_item
);
  import rsi_pkg::*;

  logic en;

  logic               v1;
  ray_t               ray1;
  logic signed [32:0] k1 [3];

  logic               v2;
  ray_t               ray2;
  logic signed [50:0] hp2 [3];
  logic signed [65:0] kq2 [3];
  logic [61:0]        r2_2;

  logic               v3;
  ray_t               ray3;
  logic signed [52:0] h3;
  logic [65:0]        kk3;
  logic [61:0]        r2_3;

  logic [52:0]        hm_c;
  logic               v4;
  ray_t               ray4;
  logic [52:0]        h4;
  logic [65:0]        kk4;
  logic [61:0]        r2_4;
  logic [49:0]        pp_hh4;
  logic [50:0]        pp_hl4;
  logic [51:0]        pp_ll4;

  logic               v5;
  ray_t               ray5;
  logic [52:0]        h5;
  logic [103:0]       hsq5;
  logic [67:0]        kq5;

  logic [103:0]       disc_c;
  front_side_t        sq_in_side;
  logic               sq_valid;
  logic [51:0]        sq_root;
  front_side_t        sq_side;

  logic signed [54:0] t1_c;
  logic [54:0]        tr_c;
  mid_item_t          item_c;

  // The whole front advances unless a finished item cannot leave.
  assign en    = !(out_valid && mid_full);
  assign ready = en;

  // Offsets from the centre.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ray1 <= in_ray;
      for (int i = 0; i < 3; i++) begin
        k1[i] <= {in_ray.o[i][31], in_ray.o[i]} - {cfg.center[i][31], cfg.center[i]};
      end
    end
  end

  // Per-axis products for d.k, k.k and the squared radius.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ray2 <= ray1;
      for (int i = 0; i < 3; i++) begin
        hp2[i] <= $signed(ray1.d[i]) * k1[i];
        kq2[i] <= k1[i] * k1[i];
      end
      r2_2 <= cfg.radius * cfg.radius;
    end
  end

  // Sums over the three axes.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      ray3 <= ray2;
      h3   <= 53'(hp2[0]) + 53'(hp2[1]) + 53'(hp2[2]);
      kk3  <= 66'(kq2[0][64:0]) + 66'(kq2[1][64:0]) + 66'(kq2[2][64:0]);
      r2_3 <= r2_2;
    end
  end

  // Square of h as three partial products of its magnitude.
  assign hm_c = h3[52] ? 53'(-h3) : 53'(h3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ray4   <= ray3;
      h4     <= h3;
      kk4    <= kk3;
      r2_4   <= r2_3;
      pp_hh4 <= hm_c[50:26] * hm_c[50:26];
      pp_hl4 <= hm_c[50:26] * hm_c[25:0];
      pp_ll4 <= hm_c[25:0] * hm_c[25:0];
    end
  end

  // Recombine h squared; r squared less k.k is formed alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ray5 <= ray4;
      h5   <= h4;
      hsq5 <= ({54'b0, pp_hh4} << 52) + ({53'b0, pp_hl4} << 27) + {52'b0, pp_ll4};
      kq5  <= {6'b0, r2_4} - {2'b0, kk4};
    end
  end

  // Discriminant in Q64; a negative one is a miss and its root is not used.
  always_comb begin
    disc_c           = hsq5 + {{4{kq5[67]}}, kq5, 32'b0};
    sq_in_side.miss  = disc_c[103];
    sq_in_side.h     = h5;
    sq_in_side.ray   = ray5;
  end

  rsi_sqrt #(
    .XW (104),
    .SW ($bits(front_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_x      (disc_c[103] ? 104'b0 : disc_c),
    .in_side   (sq_in_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Nearer root and classification; the distance is rounded half up to Q16.
  always_comb begin
    t1_c         = 55'sd0 - 55'($signed(sq_side.h)) - $signed({3'b0, sq_root});
    tr_c         = 55'(t1_c) + 55'd32768;
    item_c.ray   = sq_side.ray;
    item_c.tq    = '0;
    if (sq_side.miss) begin
      item_c.kind = KIND_MISS;
    end else if (t1_c[54] || (t1_c == '0)) begin
      item_c.kind = KIND_BEHIND;
    end else begin
      item_c.kind = KIND_HIT;
      item_c.tq   = tr_c[53:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
    if (en) begin
      out_item <= item_c;
    end
  end

endmodule

@@ src/rsi_back.sv @@
// Back end: from the distance forms the hit point, the normal length and the
// unit normal. Depends on rsi_pkg and rsi_sqrt; a long division is built inline.
module rsi_back (
  input  logic               clk,
  input  logic               rst,
  input  rsi_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  rsi_pkg::mid_item_t in_item,
  output logic               ready,
  input  logic               out_full,
  output logic               out_valid,
  output rsi_pkg::result_t   out_res
);
  import rsi_pkg::*;

  localparam int QW = 17;
  localparam int DW = 58;
  localparam logic [QW-1:0] ONE_Q16 = QW'(65536);

  typedef struct packed {
    kind_t            kind;
    logic [30:0]      distance;
    logic [2:0][31:0] p;
    logic [2:0]       neg;
    logic [2:0][40:0] mmag;
  } back_side_t;

  typedef struct packed {
    kind_t            kind;
    logic [30:0]      distance;
    logic [2:0][31:0] p;
    logic [2:0]       neg;
  } div_side_t;

  logic en;

  logic               v1;
  kind_t              kind1;
  logic [37:0]        tq1;
  logic [2:0][31:0]   o1;
  logic signed [56:0] prod1 [3];

  logic               v2;
  kind_t              kind2;
  logic [30:0]        dist2;
  logic signed [42:0] p2 [3];

  logic               v3;
  kind_t              kind3;
  logic [30:0]        dist3;
  logic [2:0][31:0]   pnt3;
  logic signed [43:0] m3 [3];

  logic [43:0]        mm_c [3];
  logic               v4;
  back_side_t         side4;
  logic [39:0]        hh4 [3];
  logic [40:0]        hl4 [3];
  logic [41:0]        ll4 [3];

  logic               v5;
  back_side_t         side5;
  logic [81:0]        msq5 [3];

  logic [83:0]        ss_c;
  logic               sq_valid;
  logic [41:0]        sq_root;
  back_side_t         sq_side;

  logic               dv   [0:QW];
  logic [2:0][DW-1:0] drem [0:QW];
  logic [2:0][QW-1:0] dq   [0:QW];
  logic [41:0]        dlen [0:QW];
  div_side_t          dside[0:QW];

  logic [QW-1:0]      qc_c [3];
  result_t            res_c;

  // The whole back advances unless a finished result cannot leave.
  assign en    = !(out_valid && out_full);
  assign ready = en;

  // Direction times distance, Q1.16 by Q22.16.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      kind1 <= in_item.kind;
      tq1   <= in_item.tq;
      o1    <= in_item.ray.o;
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= $signed(in_item.ray.d[i]) * $signed({1'b0, in_item.tq});
      end
    end
  end

  // Point, with the product rounded half up to Q16; distance saturated.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      kind2 <= kind1;
      dist2 <= (tq1 > 38'd2147483647) ? 31'h7FFF_FFFF : tq1[30:0];
      for (int i = 0; i < 3; i++) begin
        p2[i] <= 43'($signed(o1[i])) + 43'((58'(prod1[i]) + 58'sd32768) >>> 16);
      end
    end
  end

  // Offset of the point from the centre, and the saturated point.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      kind3 <= kind2;
      dist3 <= dist2;
      for (int i = 0; i < 3; i++) begin
        m3[i] <= 44'(p2[i]) - 44'($signed(cfg.center[i]));
        if (p2[i] > 43'sd2147483647) begin
          pnt3[i] <= 32'h7FFF_FFFF;
        end else if (p2[i] < -43'sd2147483648) begin
          pnt3[i] <= 32'h8000_0000;
        end else begin
          pnt3[i] <= p2[i][31:0];
        end
      end
    end
  end

  // Squares of the offsets as partial products of their magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mm_c[i] = m3[i][43] ? 44'(-m3[i]) : 44'(m3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      side4.kind     <= kind3;
      side4.distance <= dist3;
      side4.p        <= pnt3;
      for (int i = 0; i < 3; i++) begin
        side4.neg[i]  <= m3[i][43];
        side4.mmag[i] <= mm_c[i][40:0];
        hh4[i]        <= mm_c[i][40:21] * mm_c[i][40:21];
        hl4[i]        <= mm_c[i][40:21] * mm_c[i][20:0];
        ll4[i]        <= mm_c[i][20:0] * mm_c[i][20:0];
      end
    end
  end

  // Recombine the squares per axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      side5 <= side4;
      for (int i = 0; i < 3; i++) begin
        msq5[i] <= ({42'b0, hh4[i]} << 42) + ({41'b0, hl4[i]} << 22) + {40'b0, ll4[i]};
      end
    end
  end

  assign ss_c = 84'(msq5[0]) + 84'(msq5[1]) + 84'(msq5[2]);

  rsi_sqrt #(
    .XW (84),
    .SW ($bits(back_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_x      (ss_c),
    .in_side   (side5),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Division set-up: dividend is the magnitude in Q16 plus half the length.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sq_valid;
    end
    if (en) begin
      dlen[0]           <= sq_root;
      dside[0].kind     <= sq_side.kind;
      dside[0].distance <= sq_side.distance;
      dside[0].p        <= sq_side.p;
      dside[0].neg      <= sq_side.neg;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= {1'b0, sq_side.mmag[i], 16'b0} + DW'(sq_root >> 1);
        dq[0][i]   <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int J = QW - 1 - s;
    logic [DW-1:0] dl;

    assign dl = DW'(dlen[s]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
      if (en) begin
        dlen[s+1]  <= dlen[s];
        dside[s+1] <= dside[s];
        for (int i = 0; i < 3; i++) begin
          if (drem[s][i] >= dl) begin
            drem[s+1][i] <= drem[s][i] - dl;
            dq[s+1][i]   <= dq[s][i] | (QW'(1) << J);
          end else begin
            drem[s+1][i] <= drem[s][i];
            dq[s+1][i]   <= dq[s][i];
          end
        end
      end
    end
  end

  // Signed, clamped normal; everything but the kind is zero unless a hit.
  always_comb begin
    res_c      = '0;
    res_c.kind = dside[QW].kind;
    for (int i = 0; i < 3; i++) begin
      qc_c[i] = (dq[QW][i] > ONE_Q16) ? ONE_Q16 : dq[QW][i];
    end
    if (dside[QW].kind == KIND_HIT) begin
      res_c.distance = dside[QW].distance;
      res_c.p        = dside[QW].p;
      if (dlen[QW] != '0) begin
        for (int i = 0; i < 3; i++) begin
          res_c.n[i] = dside[QW].neg[i] ? (18'd0 - {1'b0, qc_c[i]}) : {1'b0, qc_c[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
    if (en) begin
      out_res <= res_c;
    end
  end

endmodule
